// ===== rtl/lkpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lkpr_pkg
// Shared types and constants for the ladder key press/hold/repeat unit.
// ----------------------------------------------------------------------------
package lkpr_pkg;

   // Field widths
   localparam int ADC_W   = 10;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int KEY_W   = 2;
   localparam int KIND_W  = 2;

   // Ladder thresholds (strictly above)
   localparam logic [ADC_W-1:0] KEY_MIDDLE_ABOVE = 10'd660;
   localparam logic [ADC_W-1:0] KEY_LEFT_ABOVE   = 10'd530;
   localparam logic [ADC_W-1:0] KEY_RIGHT_ABOVE  = 10'd370;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_NONE   = 2'd0;
   localparam logic [KEY_W-1:0] KEY_MIDDLE = 2'd1;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 2'd2;
   localparam logic [KEY_W-1:0] KEY_RIGHT  = 2'd3;

   // Action kinds
   localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HOLD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 2'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] HOLD_TIME_RESET       = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RESET = 16'd200;

   // Default depth of the action queue (at least two)
   localparam int RSP_DEPTH_DEFAULT = 4;

   // One action
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KIND_W-1:0] kind;
      logic              last;
   } action_type;

   // Actions produced by one item, slot 0 first
   typedef struct packed {
      logic [1:0] count;
      action_type slot0;
      action_type slot1;
   } push_type;

endpackage

// ===== rtl/lkpr_if.sv =====
// ----------------------------------------------------------------------------
// lkpr channel interfaces
// Valid/ready channels for samples, actions and register writes.
// ----------------------------------------------------------------------------
interface lkpr_req_if;
   logic                        valid;
   logic                        ready;
   logic [lkpr_pkg::ADC_W-1:0]  adc_level;
   logic [lkpr_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, output adc_level, output now_ms, input ready);
   modport sink   (input valid, input adc_level, input now_ms, output ready);
endinterface

interface lkpr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lkpr_pkg::KEY_W-1:0]  action_key;
   logic [lkpr_pkg::KIND_W-1:0] action_kind;
   logic                        last_in_run;

   modport source (output valid, output action_key, output action_kind,
                   output last_in_run, input ready);
   modport sink   (input valid, input action_key, input action_kind,
                   input last_in_run, output ready);
endinterface

interface lkpr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lkpr_pkg::CSR_IDX_W-1:0] index;
   logic [lkpr_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lkpr_core.sv =====
// ----------------------------------------------------------------------------
// lkpr_core
// Input register, key decode, press/hold/repeat state and action generation.
// ----------------------------------------------------------------------------
module lkpr_core (
   input  logic                           clock,
   input  logic                           reset,
   // register writes
   input  logic                           csr_valid,
   input  logic [lkpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lkpr_pkg::CFG_W-1:0]     csr_data,
   // samples
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [lkpr_pkg::ADC_W-1:0]     in_adc_level,
   input  logic [lkpr_pkg::TIME_W-1:0]    in_now_ms,
   // queue side
   input  logic                           space_ok,
   output lkpr_pkg::push_type             push
);
   import lkpr_pkg::*;

   logic [CFG_W-1:0]  hold_time_ff,  hold_time_in;
   logic [CFG_W-1:0]  repeat_int_ff, repeat_int_in;
   logic              in_valid_ff,   in_valid_in;
   logic [ADC_W-1:0]  adc_ff;
   logic [TIME_W-1:0] now_ff;
   logic [KEY_W-1:0]  tracked_ff,    tracked_in;
   logic              hold_ff,       hold_in;
   logic [TIME_W-1:0] start_ff,      start_in;
   logic [TIME_W-1:0] last_rep_ff,   last_rep_in;

   logic              proc;
   logic [KEY_W-1:0]  key;
   logic              new_press;
   logic              hold0;
   logic [TIME_W-1:0] held;
   logic [TIME_W-1:0] since_rep;
   logic              fire_hold;
   logic              fire_rep;
   logic              fire_short;

   // Register writes; unknown indexes are dropped
   always_comb begin
      hold_time_in  = hold_time_ff;
      repeat_int_in = repeat_int_ff;
      if (csr_valid) begin
         if (csr_index == CSR_HOLD_TIME) begin
            hold_time_in = csr_data;
         end else if (csr_index == CSR_REPEAT_INTERVAL) begin
            repeat_int_in = csr_data;
         end
      end
   end

   // Input register handshake: refill as the held item moves on
   assign proc        = in_valid_ff && space_ok;
   assign in_ready    = !in_valid_ff || space_ok;
   assign in_valid_in = in_ready ? in_valid : in_valid_ff;

   // Ladder decode
   always_comb begin
      priority if (adc_ff > KEY_MIDDLE_ABOVE) begin
         key = KEY_MIDDLE;
      end else if (adc_ff > KEY_LEFT_ABOVE) begin
         key = KEY_LEFT;
      end else if (adc_ff > KEY_RIGHT_ABOVE) begin
         key = KEY_RIGHT;
      end else begin
         key = KEY_NONE;
      end
   end

   // Press, hold and repeat decisions
   always_comb begin
      new_press = (key != KEY_NONE) && (key != tracked_ff);
      start_in  = new_press ? now_ff : start_ff;
      hold0     = new_press ? 1'b0 : hold_ff;
      held      = now_ff - start_in;
      fire_hold = (key != KEY_NONE) && !hold0 && (held >= {16'd0, hold_time_ff});
      // a hold fired on this item resets the repeat reference to now
      since_rep = fire_hold ? '0 : (now_ff - last_rep_ff);
      fire_rep  = (key != KEY_NONE) && (hold0 || fire_hold) &&
                  (since_rep >= {16'd0, repeat_int_ff});
      fire_short = (key == KEY_NONE) && (tracked_ff != KEY_NONE) && !hold_ff;

      last_rep_in = (fire_hold || fire_rep) ? now_ff : last_rep_ff;
      if (key == KEY_NONE) begin
         tracked_in = KEY_NONE;
         hold_in    = 1'b0;
      end else begin
         tracked_in = key;
         hold_in    = hold0 || fire_hold;
      end
   end

   // Action slots for the queue
   always_comb begin
      push.count = 2'd0;
      push.slot0 = '{key: key, kind: KIND_HOLD, last: 1'b1};
      push.slot1 = '{key: key, kind: KIND_REPEAT, last: 1'b1};
      if (proc) begin
         if (fire_short) begin
            push.count = 2'd1;
            push.slot0 = '{key: tracked_ff, kind: KIND_SHORT, last: 1'b1};
         end else if (fire_hold && fire_rep) begin
            push.count      = 2'd2;
            push.slot0.last = 1'b0;
         end else if (fire_hold) begin
            push.count = 2'd1;
         end else if (fire_rep) begin
            push.count = 2'd1;
            push.slot0 = '{key: key, kind: KIND_REPEAT, last: 1'b1};
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff  <= HOLD_TIME_RESET;
         repeat_int_ff <= REPEAT_INTERVAL_RESET;
         in_valid_ff   <= 1'b0;
         tracked_ff    <= KEY_NONE;
         hold_ff       <= 1'b0;
         start_ff      <= '0;
         last_rep_ff   <= '0;
      end else begin
         hold_time_ff  <= hold_time_in;
         repeat_int_ff <= repeat_int_in;
         in_valid_ff   <= in_valid_in;
         if (proc) begin
            tracked_ff  <= tracked_in;
            hold_ff     <= hold_in;
            start_ff    <= start_in;
            last_rep_ff <= last_rep_in;
         end
      end
   end

   // Sample payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         adc_ff <= in_adc_level;
         now_ff <= in_now_ms;
      end
   end

endmodule

// ===== rtl/lkpr_queue.sv =====
// ----------------------------------------------------------------------------
// lkpr_queue
// Action queue: takes up to two actions a cycle, hands out one.
// ----------------------------------------------------------------------------
module lkpr_queue #(
   parameter int DEPTH = lkpr_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lkpr_pkg::push_type    push,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lkpr_pkg::action_type  out_action
);
   import lkpr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   action_type       mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // Room for a full pair of actions
   assign space_ok   = (CNT_W'(DEPTH) - count_ff) >= CNT_W'(2);
   assign out_valid  = count_ff != '0;
   assign out_action = mem[rd_ptr_ff];
   assign pop        = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_next = bump(wr_ptr_ff);
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = bump(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_next] <= push.slot1;
      end
   end

endmodule

// ===== rtl/ladder_key_press_hold_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// ladder_key_press_hold_repeat_unit
// Path: a sample waits in the input register until the queue has room for
//   two actions, and its actions are then written into the queue.
// Throughput: one sample per cycle while the queue has room for two actions;
//   hold and repeat together queue two actions; one drains per ready cycle.
// Reset: synchronous, active high; no key tracked, registers at 500 and 200 ms.
// ----------------------------------------------------------------------------
module ladder_key_press_hold_repeat_unit #(
   parameter int RSP_DEPTH = lkpr_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lkpr_req_if.sink   req_ch,
   lkpr_rsp_if.source rsp_ch,
   lkpr_csr_if.sink   csr_ch
);
   import lkpr_pkg::*;

   push_type   push;
   logic       space_ok;
   action_type head;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   lkpr_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .in_adc_level (req_ch.adc_level),
      .in_now_ms    (req_ch.now_ms),
      .space_ok     (space_ok),
      .push         (push)
   );

   lkpr_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_action (head)
   );

   assign rsp_ch.action_key  = head.key;
   assign rsp_ch.action_kind = head.kind;
   assign rsp_ch.last_in_run = head.last;

endmodule

// ===== sim/ladder_key_press_hold_repeat_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ladder_key_press_hold_repeat_unit_tb
// Self-checking bench for the ladder key press/hold/repeat unit. Ladder
// samples with timestamps go in over the request channel. A key tracker in
// the bench predicts the short-press, hold and repeat actions, and each action
// that leaves the block is compared in order with the oldest prediction.
// Register writes happen only while the block is idle. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module ladder_key_press_hold_repeat_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkpr_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_GAP      = 11;
   localparam int DRAIN_TAIL   = 8;          // margin after the last owed action has been seen
   localparam int RUN_LIMIT_NS = 20_000_000; // far beyond the slowest correct run
   localparam int PHASE_ITEMS  = 125;
   localparam int RANDOM_PHASES = 6;
   localparam logic [ADC_W-1:0] ADC_MAX = {ADC_W{1'b1}};

   // Indexes past the two registers; writes there must leave the block unchanged
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lkpr_req_if req_bus ();
   lkpr_rsp_if rsp_bus ();
   lkpr_csr_if csr_bus ();

   ladder_key_press_hold_repeat_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Stall switches for each side, flipped between stretches of traffic
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int fail_count = 0;

   // Actions still owed by the block, oldest first
   action_type pending_actions[$];

   // Key tracker state and register copies
   logic [KEY_W-1:0]  tracked_key;
   bit                hold_armed;
   logic [TIME_W-1:0] press_start_ms;
   logic [TIME_W-1:0] last_repeat_ms;
   logic [CFG_W-1:0]  hold_time_cfg;
   logic [CFG_W-1:0]  repeat_cfg;

   // Running timestamp for the random part
   logic [TIME_W-1:0] stamp_ms;

   // ---------------------------------------------------------------------------
   // Key tracker: decodes one sample and queues the actions it fires
   // ---------------------------------------------------------------------------
   task automatic advance_key_tracker(input logic [ADC_W-1:0] level,
                                      input logic [TIME_W-1:0] now);
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] since;
      action_type        fired[$];
      action_type        act;

      if (level > KEY_MIDDLE_ABOVE)     key = KEY_MIDDLE;
      else if (level > KEY_LEFT_ABOVE)  key = KEY_LEFT;
      else if (level > KEY_RIGHT_ABOVE) key = KEY_RIGHT;
      else                              key = KEY_NONE;

      // a different key restarts the press, the old one gives nothing
      if (key != KEY_NONE && key != tracked_key) begin
         press_start_ms = now;
         hold_armed     = 1'b0;
         tracked_key    = key;
      end

      if (key != KEY_NONE) begin
         held = now - press_start_ms;
         if (!hold_armed && held >= TIME_W'(hold_time_cfg)) begin
            hold_armed     = 1'b1;
            last_repeat_ms = now;
            act = '{key: key, kind: KIND_HOLD, last: 1'b0};
            fired.push_back(act);
         end
         since = now - last_repeat_ms;
         if (hold_armed && since >= TIME_W'(repeat_cfg)) begin
            last_repeat_ms = now;
            act = '{key: key, kind: KIND_REPEAT, last: 1'b0};
            fired.push_back(act);
         end
      end else if (tracked_key != KEY_NONE) begin
         // release: short press only when the hold never fired
         if (!hold_armed) begin
            act = '{key: tracked_key, kind: KIND_SHORT, last: 1'b0};
            fired.push_back(act);
         end
         tracked_key = KEY_NONE;
         hold_armed  = 1'b0;
      end

      if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
      foreach (fired[i]) pending_actions.push_back(fired[i]);
   endtask

   // ---------------------------------------------------------------------------
   // Request side: one sample per call, random gap before it
   // ---------------------------------------------------------------------------
   task automatic send_sample(input logic [ADC_W-1:0] level, input logic [TIME_W-1:0] now);
      int gap;

      gap = req_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.adc_level <= level;
      req_bus.now_ms    <= now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      advance_key_tracker(level, now);
   endtask

   // Holds the request side until every owed action has come back
   task automatic drain_actions();
      req_bus.valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Register write; only called with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_HOLD_TIME)            hold_time_cfg = value;
      else if (idx == CSR_REPEAT_INTERVAL) repeat_cfg    = value;
      @(posedge clock);
   endtask

   // Random ladder level that decodes to the given key
   function automatic logic [ADC_W-1:0] level_for(input logic [KEY_W-1:0] key);
      case (key)
         KEY_MIDDLE: return ADC_W'($urandom_range(int'(KEY_MIDDLE_ABOVE) + 1, int'(ADC_MAX)));
         KEY_LEFT:   return ADC_W'($urandom_range(int'(KEY_LEFT_ABOVE) + 1,
                                                  int'(KEY_MIDDLE_ABOVE)));
         KEY_RIGHT:  return ADC_W'($urandom_range(int'(KEY_RIGHT_ABOVE) + 1,
                                                  int'(KEY_LEFT_ABOVE)));
         default:    return ADC_W'($urandom_range(0, int'(KEY_RIGHT_ABOVE)));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Action checker with random back-pressure
   // ---------------------------------------------------------------------------
   initial begin
      action_type want;
      int         stall;

      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_actions.size() == 0) begin
            $error("action with none owed: key %0d kind %0d last %0d",
                   rsp_bus.action_key, rsp_bus.action_kind, rsp_bus.last_in_run);
            fail_count++;
         end else begin
            want = pending_actions.pop_front();
            if (rsp_bus.action_key !== want.key) begin
               $error("action_key: expected %0d, got %0d", want.key, rsp_bus.action_key);
               fail_count++;
            end
            if (rsp_bus.action_kind !== want.kind) begin
               $error("action_kind: expected %0d, got %0d", want.kind, rsp_bus.action_kind);
               fail_count++;
            end
            if (rsp_bus.last_in_run !== want.last) begin
               $error("last_in_run: expected %0d, got %0d", want.last, rsp_bus.last_in_run);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Decode thresholds, short press, hold, repeat, wrap; reset register values
   // ---------------------------------------------------------------------------
   task automatic test_decode_and_timing();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      send_sample(10'd0,   32'd0);        // nothing tracked, nothing fires
      send_sample(10'd370, 32'd10);       // threshold itself is no key
      send_sample(10'd371, 32'd20);       // right key pressed
      send_sample(ADC_MAX, 32'd30);       // middle key replaces it, no short press
      send_sample(10'd661, 32'd40);
      send_sample(10'd660, 32'd50);       // left key replaces it
      send_sample(10'd531, 32'd60);
      send_sample(10'd530, 32'd70);       // right key replaces it
      send_sample(10'd0,   32'd80);       // release before hold: short press
      // hold and repeat with the timestamp wrapping through zero
      send_sample(10'd800, 32'hFFFF_FF00);
      send_sample(10'd800, 32'h0000_00F3); // one short of the hold time
      send_sample(10'd800, 32'h0000_00F4); // hold fires
      send_sample(10'd800, 32'h0000_01BB); // one short of the repeat interval
      send_sample(10'd800, 32'h0000_01BC); // repeat fires
      send_sample(10'd0,   32'h0000_0200); // release after hold: silent
      send_sample(10'd0,   32'h0000_0300);
      drain_actions();
   endtask

   // ---------------------------------------------------------------------------
   // Register extremes, double action on one sample, ignored register indexes
   // ---------------------------------------------------------------------------
   task automatic test_register_extremes();
      write_reg(CSR_HOLD_TIME, 16'h0000);
      write_reg(CSR_REPEAT_INTERVAL, 16'h0000);
      send_sample(10'd600, 32'd5);         // hold and repeat together
      send_sample(10'd600, 32'd5);         // repeat on every held sample
      send_sample(ADC_MAX, 32'hFFFF_FFFF); // key change with zero hold time
      send_sample(10'd0,   32'd6);
      drain_actions();

      write_reg(CSR_HOLD_TIME, 16'hFFFF);
      write_reg(CSR_REPEAT_INTERVAL, 16'hFFFF);
      send_sample(10'd400, 32'd100);
      send_sample(10'd400, 32'd100 + 32'd65534);
      send_sample(10'd400, 32'd100 + 32'd65535);
      send_sample(10'd400, 32'd100 + 32'd131069);
      send_sample(10'd400, 32'd100 + 32'd131070);
      send_sample(10'd0,   32'd100 + 32'd131071);
      drain_actions();

      // spare indexes: the long hold time must still apply
      write_reg(CSR_SPARE_LO, 16'h0000);
      write_reg(CSR_SPARE_HI, 16'h0000);
      send_sample(10'd700, 32'd0);
      send_sample(10'd700, 32'd1);
      send_sample(10'd0,   32'd2);
      drain_actions();
   endtask

   // ---------------------------------------------------------------------------
   // Random press episodes across several register settings
   // ---------------------------------------------------------------------------
   task automatic test_random_episodes();
      logic [CFG_W-1:0] hold_pick;
      logic [CFG_W-1:0] repeat_pick;
      logic [KEY_W-1:0] key;
      int unsigned      step_max;
      int               sent;
      int               len;

      stamp_ms = $urandom();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin hold_pick = 16'd0;     repeat_pick = 16'd0;     end
            1:       begin hold_pick = 16'd0;     repeat_pick = 16'd7;     end
            2:       begin hold_pick = 16'd15;    repeat_pick = 16'd0;     end
            3:       begin hold_pick = 16'd40;    repeat_pick = 16'd10;    end
            4:       begin hold_pick = 16'hFFFF;  repeat_pick = 16'hFFFF;  end
            default: begin
               hold_pick   = CFG_W'($urandom_range(0, 16'hFFFF));
               repeat_pick = CFG_W'($urandom_range(0, 16'hFFFF));
            end
         endcase
         drain_actions();
         write_reg(CSR_REPEAT_INTERVAL, repeat_pick);
         write_reg(CSR_HOLD_TIME, hold_pick);
         step_max = ((hold_pick > repeat_pick) ? hold_pick : repeat_pick) / 3 + 2;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // stretches with and without stalls
            req_gaps = ($urandom_range(0, 3) != 0);
            rsp_gaps = ($urandom_range(0, 3) != 0);
            key = KEY_W'($urandom_range(1, 3));
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++) begin
               stamp_ms = stamp_ms + $urandom_range(0, step_max);
               if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom_range(1, 3));
               send_sample(level_for(key), stamp_ms);
               sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
               stamp_ms = stamp_ms + $urandom_range(0, step_max);
               send_sample(level_for(KEY_NONE), stamp_ms);
               sent++;
            end
            // noise: any level, sometimes a jump to any timestamp
            if ($urandom_range(0, 5) == 0) begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 7) == 0) stamp_ms = $urandom();
                  else stamp_ms = stamp_ms + $urandom_range(0, step_max);
                  send_sample(ADC_W'($urandom_range(0, int'(ADC_MAX))), stamp_ms);
                  sent++;
               end
            end
            if ($urandom_range(0, 24) == 0) drain_actions();
         end
      end
      drain_actions();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.adc_level = '0;
      req_bus.now_ms    = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_HOLD_TIME;
      csr_bus.data      = '0;
      tracked_key    = KEY_NONE;
      hold_armed     = 1'b0;
      press_start_ms = '0;
      last_repeat_ms = '0;
      hold_time_cfg  = HOLD_TIME_RESET;
      repeat_cfg     = REPEAT_INTERVAL_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_decode_and_timing();
      test_register_extremes();
      test_random_episodes();

      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #RUN_LIMIT_NS;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
